[rtl/rbs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record bubble sorter package
// Shared types, codes and constants for the record store and its sequencer.
// ----------------------------------------------------------------------------
package rbs_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int ID_W         = 31;
	localparam int SCORE_W      = 14;
	localparam int ACTION_W     = 2;
	localparam int KIND_W       = 3;

	localparam logic [SCORE_W-1:0] SCORE_MAX = SCORE_W'(10000);

	// Request action codes. The last code is unused and is ignored.
	localparam logic [ACTION_W-1:0] ACT_ADD      = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SORT     = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_EXTREMES = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_UNUSED   = 2'd3;

	// Result kind codes.
	localparam logic [KIND_W-1:0] KIND_ENTRY = 3'd0;
	localparam logic [KIND_W-1:0] KIND_BEST  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_WORST = 3'd2;
	localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FULL  = 3'd4;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [ID_W-1:0]     record_id;
		logic [SCORE_W-1:0]  score;
	} req_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [ID_W-1:0]    record_id_res;
		logic [SCORE_W-1:0] score_res;
		logic               last;
	} res_t;

	// One stored record.
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] score;
	} rec_t;

	// Write request into the record store.
	typedef struct packed {
		logic en;
		rec_t rec;
	} wr_t;

	// Result of the shared compare unit: the lower and higher record.
	typedef struct packed {
		rec_t lo;
		rec_t hi;
	} cmp_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PASS,
		ST_PASS_END,
		ST_EMIT,
		ST_SCAN_RD,
		ST_SCAN_BEST,
		ST_SCAN_WORST,
		ST_XBEST,
		ST_XWORST
	} state_t;

endpackage

[rtl/record_bubble_sorter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record bubble sorter
// Record store with add, stable ascending sort listed highest first, and
// best/worst report, run by a small sequencer around one compare unit.
// ----------------------------------------------------------------------------
// Usage: a request is taken on the rising edge where start is high and busy is
// low; req carries the action, id and score. Results appear on res for exactly
// one cycle with strobe high; the receiver cannot hold them off, so there is
// no stall case. The final result of each request has res.last set.
// Steps, with n records held:
//   add            - no result unless the store is full, in which case the
//                    rejected record comes back in the next cycle.
//   sort           - a bubble pass over m records (one memory read and one
//                    write a cycle) runs for m = n down to 2, then the n
//                    records are listed highest first, each one read from
//                    the store and then registered on res.
//   best and worst - a read, a best and a worst compare per record, then a report of each.
// An empty store answers sort or best/worst with one result in the next cycle.
// The pace is set by the record memory, one read and one write port, and
// the one shared compare unit. Reset clears the record count and the
// sequencer only; store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module record_bubble_sorter #(
	parameter int CAPACITY = rbs_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rbs_pkg::req_t req,
	output logic          strobe,
	output rbs_pkg::res_t res
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	rbs_pkg::state_t   state_q, state_d;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     lim_q;
	logic              pend_q;
	logic              pend_last_q;
	rbs_pkg::rec_t     carry_q, best_q, worst_q;
	rbs_pkg::rec_t     rd_q;
	rbs_pkg::res_t     res_q;
	logic              strobe_q;

	logic                      accept;
	logic [rbs_pkg::SCORE_W-1:0] score_cl;
	logic [CW-1:0]             count_m1, idx_m2, lim_m1;
	rbs_pkg::wr_t              wr;
	logic [IW-1:0]             waddr;
	rbs_pkg::rec_t             cmp_a, cmp_b;
	rbs_pkg::cmp_out_t         cmp_y;
	logic                      res_load;
	rbs_pkg::res_t             res_next;

	assign busy     = (state_q != rbs_pkg::ST_IDLE) || pend_q;
	assign accept   = start && !busy;
	assign score_cl = (req.score > rbs_pkg::SCORE_MAX) ? rbs_pkg::SCORE_MAX : req.score;
	assign count_m1 = count_q - CW'(1);
	assign idx_m2   = idx_q - CW'(2);
	assign lim_m1   = lim_q - CW'(1);

	// The index counter addresses every read: the sort, listing and scan all
	// walk the store through it.
	rbs_store #(
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.wr   (wr),
		.waddr(waddr),
		.raddr(idx_q[IW-1:0]),
		.rdata(rd_q)
	);

	rbs_cmp u_cmp (
		.a(cmp_a),
		.b(cmp_b),
		.y(cmp_y)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rbs_pkg::ST_IDLE: begin
				if (accept) begin
					case (req.action)
						rbs_pkg::ACT_SORT: begin
							if (count_q == CW'(1)) begin
								state_d = rbs_pkg::ST_EMIT;
							end else if (count_q != '0) begin
								state_d = rbs_pkg::ST_PASS;
							end
						end
						rbs_pkg::ACT_EXTREMES: begin
							if (count_q != '0) begin
								state_d = rbs_pkg::ST_SCAN_RD;
							end
						end
						default: state_d = rbs_pkg::ST_IDLE;
					endcase
				end
			end
			rbs_pkg::ST_PASS: begin
				if (idx_q == lim_q) begin
					state_d = rbs_pkg::ST_PASS_END;
				end
			end
			rbs_pkg::ST_PASS_END: begin
				state_d = (lim_q == CW'(2)) ? rbs_pkg::ST_EMIT : rbs_pkg::ST_PASS;
			end
			rbs_pkg::ST_EMIT: begin
				if (idx_q == '0) begin
					state_d = rbs_pkg::ST_IDLE;
				end
			end
			rbs_pkg::ST_SCAN_RD:   state_d = rbs_pkg::ST_SCAN_BEST;
			rbs_pkg::ST_SCAN_BEST: state_d = rbs_pkg::ST_SCAN_WORST;
			rbs_pkg::ST_SCAN_WORST: begin
				state_d = (idx_q == count_m1) ? rbs_pkg::ST_XBEST : rbs_pkg::ST_SCAN_RD;
			end
			rbs_pkg::ST_XBEST:  state_d = rbs_pkg::ST_XWORST;
			rbs_pkg::ST_XWORST: state_d = rbs_pkg::ST_IDLE;
			default:            state_d = rbs_pkg::ST_IDLE;
		endcase
	end

	// Store writes, compare operands and result loads.
	always_comb begin
		wr       = '0;
		waddr    = '0;
		cmp_a    = carry_q;
		cmp_b    = rd_q;
		res_load = 1'b0;
		res_next = '0;
		case (state_q)
			rbs_pkg::ST_IDLE: begin
				if (accept) begin
					case (req.action)
						rbs_pkg::ACT_ADD: begin
							if (count_q >= CW'(CAPACITY)) begin
								res_load               = 1'b1;
								res_next.kind          = rbs_pkg::KIND_FULL;
								res_next.record_id_res = req.record_id;
								res_next.score_res     = score_cl;
								res_next.last          = 1'b1;
							end else begin
								wr.en        = 1'b1;
								wr.rec.id    = req.record_id;
								wr.rec.score = score_cl;
								waddr        = count_q[IW-1:0];
							end
						end
						rbs_pkg::ACT_SORT, rbs_pkg::ACT_EXTREMES: begin
							if (count_q == '0) begin
								res_load      = 1'b1;
								res_next.kind = rbs_pkg::KIND_EMPTY;
								res_next.last = 1'b1;
							end
						end
						default: res_load = 1'b0;
					endcase
				end
			end
			rbs_pkg::ST_PASS: begin
				// The lower of carry and the fresh record drops two places behind
				// the read pointer; the higher rides on.
				if (idx_q >= CW'(2)) begin
					wr.en  = 1'b1;
					wr.rec = cmp_y.lo;
					waddr  = idx_m2[IW-1:0];
				end
			end
			rbs_pkg::ST_PASS_END: begin
				wr.en  = 1'b1;
				wr.rec = carry_q;
				waddr  = lim_m1[IW-1:0];
			end
			rbs_pkg::ST_SCAN_BEST: begin
				cmp_a = rd_q;
				cmp_b = best_q;
			end
			rbs_pkg::ST_SCAN_WORST: begin
				cmp_a = worst_q;
				cmp_b = rd_q;
			end
			rbs_pkg::ST_XBEST: begin
				res_load               = 1'b1;
				res_next.kind          = rbs_pkg::KIND_BEST;
				res_next.record_id_res = best_q.id;
				res_next.score_res     = best_q.score;
				res_next.last          = 1'b0;
			end
			rbs_pkg::ST_XWORST: begin
				res_load               = 1'b1;
				res_next.kind          = rbs_pkg::KIND_WORST;
				res_next.record_id_res = worst_q.id;
				res_next.score_res     = worst_q.score;
				res_next.last          = 1'b1;
			end
			default: res_load = 1'b0;
		endcase
		// Listed entries arrive in the cycle after their read was issued.
		if (pend_q) begin
			res_load               = 1'b1;
			res_next.kind          = rbs_pkg::KIND_ENTRY;
			res_next.record_id_res = rd_q.id;
			res_next.score_res     = rd_q.score;
			res_next.last          = pend_last_q;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rbs_pkg::ST_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			lim_q    <= '0;
			pend_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			pend_q   <= (state_q == rbs_pkg::ST_EMIT);
			strobe_q <= res_load;
			case (state_q)
				rbs_pkg::ST_IDLE: begin
					if (accept && req.action == rbs_pkg::ACT_ADD &&
					    count_q < CW'(CAPACITY)) begin
						count_q <= count_q + CW'(1);
					end
					idx_q <= '0;
					lim_q <= count_q;
				end
				rbs_pkg::ST_PASS:       idx_q <= idx_q + CW'(1);
				rbs_pkg::ST_PASS_END: begin
					lim_q <= lim_m1;
					idx_q <= (lim_q == CW'(2)) ? count_m1 : '0;
				end
				rbs_pkg::ST_EMIT:       idx_q <= idx_q - CW'(1);
				rbs_pkg::ST_SCAN_WORST: idx_q <= idx_q + CW'(1);
				default:                idx_q <= idx_q;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		pend_last_q <= (idx_q == '0);
		if (res_load) begin
			res_q <= res_next;
		end
		if (state_q == rbs_pkg::ST_PASS) begin
			if (idx_q == CW'(1)) begin
				carry_q <= rd_q;
			end else if (idx_q >= CW'(2)) begin
				carry_q <= cmp_y.hi;
			end
		end
		if (state_q == rbs_pkg::ST_SCAN_BEST) begin
			best_q <= (idx_q == '0) ? rd_q : cmp_y.hi;
		end
		if (state_q == rbs_pkg::ST_SCAN_WORST) begin
			worst_q <= (idx_q == '0) ? rd_q : cmp_y.lo;
		end
	end

	assign strobe = strobe_q;
	assign res    = res_q;

	// The record count never passes the store size.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("record count exceeds capacity");

	// A bubble pass always covers at least two records; its index never passes the pass limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rbs_pkg::ST_PASS |-> lim_q >= CW'(2) && lim_q <= count_q && idx_q <= lim_q)
		else $error("bubble pass bounds broken");

	// A sort of a non-empty store keeps the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.action == rbs_pkg::ACT_SORT && count_q != '0 |=> busy)
		else $error("sort request did not start");

	// Listed entries come out only straight after a listing cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> $past(state_q) == rbs_pkg::ST_EMIT)
		else $error("stray listed entry");

endmodule

[rtl/rbs_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record store
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module rbs_store #(
	parameter int DEPTH = rbs_pkg::CAPACITY_DEF,
	localparam int IW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  rbs_pkg::wr_t      wr,
	input  logic [IW-1:0]     waddr,
	input  logic [IW-1:0]     raddr,
	output rbs_pkg::rec_t     rdata
);

	rbs_pkg::rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[waddr] <= wr.rec;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/rbs_cmp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Compare and order unit
// Orders two records by score; on equal scores the first operand stays low.
// ----------------------------------------------------------------------------
module rbs_cmp (
	input  rbs_pkg::rec_t     a,
	input  rbs_pkg::rec_t     b,
	output rbs_pkg::cmp_out_t y
);

	logic gt;

	// Strict greater-than keeps equal records in their order.
	assign gt   = a.score > b.score;
	assign y.lo = gt ? b : a;
	assign y.hi = gt ? a : b;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record bubble sorter testbench
// Sends add, sort and best/worst requests through the start/busy handshake.
// A behavioural copy of the record store predicts every result, and each
// strobed result is checked in order against it.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int RANDOM_REQUESTS = 340;
	localparam int QUIET_TAIL      = 60;   // last requests are sent back to back
	localparam int DRAIN_CYCLES    = 700;  // longer than one full sort and listing
	localparam int ERR_PRINT_MAX   = 20;

	// The record store as the block should hold it, plus the queue of results
	// that the accepted requests have still to produce.
	class record_book;
		logic [rbs_pkg::ID_W-1:0]    ids    [rbs_pkg::CAPACITY_DEF];
		logic [rbs_pkg::SCORE_W-1:0] scores [rbs_pkg::CAPACITY_DEF];
		int                          held;
		rbs_pkg::res_t               pending[$];
		int                          errors;
		int                          checked;
		int                 n_add, n_reject, n_sort, n_extremes, n_empty, n_ignored;

		function new();
			held = 0;
			errors = 0;
			checked = 0;
			n_add = 0;
			n_reject = 0;
			n_sort = 0;
			n_extremes = 0;
			n_empty = 0;
			n_ignored = 0;
		endfunction

		function void queue_report(logic [rbs_pkg::KIND_W-1:0] kind,
				logic [rbs_pkg::ID_W-1:0] id, logic [rbs_pkg::SCORE_W-1:0] sc,
				logic last);
			rbs_pkg::res_t r;
			r.kind = kind;
			r.record_id_res = id;
			r.score_res = sc;
			r.last = last;
			pending = {pending, r};
		endfunction

		// Stable ascending bubble sort: swap only on strictly greater.
		function void sort_by_score();
			logic [rbs_pkg::ID_W-1:0]    ti;
			logic [rbs_pkg::SCORE_W-1:0] ts;
			for (int pass = 0; pass + 1 < held; pass++) begin
				for (int j = 0; j + 1 < held - pass; j++) begin
					if (scores[j] > scores[j+1]) begin
						ts = scores[j];
						ti = ids[j];
						scores[j] = scores[j+1];
						ids[j] = ids[j+1];
						scores[j+1] = ts;
						ids[j+1] = ti;
					end
				end
			end
		endfunction

		function void note_request(rbs_pkg::req_t r);
			logic [rbs_pkg::SCORE_W-1:0] sc;
			int best;
			int worst;
			sc = (r.score > rbs_pkg::SCORE_MAX) ? rbs_pkg::SCORE_MAX : r.score;
			case (r.action)
				rbs_pkg::ACT_ADD: begin
					if (held >= rbs_pkg::CAPACITY_DEF) begin
						queue_report(rbs_pkg::KIND_FULL, r.record_id, sc, 1'b1);
						n_reject++;
					end else begin
						ids[held] = r.record_id;
						scores[held] = sc;
						held++;
						n_add++;
					end
				end
				rbs_pkg::ACT_SORT: begin
					n_sort++;
					if (held == 0) begin
						queue_report(rbs_pkg::KIND_EMPTY, '0, '0, 1'b1);
						n_empty++;
					end else begin
						sort_by_score();
						for (int i = held - 1; i >= 0; i--)
							queue_report(rbs_pkg::KIND_ENTRY, ids[i], scores[i], i == 0);
					end
				end
				rbs_pkg::ACT_EXTREMES: begin
					n_extremes++;
					if (held == 0) begin
						queue_report(rbs_pkg::KIND_EMPTY, '0, '0, 1'b1);
						n_empty++;
					end else begin
						best = 0;
						worst = 0;
						for (int i = 1; i < held; i++) begin
							if (scores[i] > scores[best])
								best = i;
							if (scores[i] < scores[worst])
								worst = i;
						end
						queue_report(rbs_pkg::KIND_BEST, ids[best], scores[best], 1'b0);
						queue_report(rbs_pkg::KIND_WORST, ids[worst], scores[worst], 1'b1);
					end
				end
				default: n_ignored++;
			endcase
		endfunction

		function string show(rbs_pkg::res_t r);
			return $sformatf("kind %0d id %h score %0d last %0b",
				r.kind, r.record_id_res, r.score_res, r.last);
		endfunction

		function void check_report(rbs_pkg::res_t got);
			rbs_pkg::res_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= ERR_PRINT_MAX)
					$display("%0t ns: result with nothing awaited: expected none, got %s",
						$time, show(got));
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.kind !== want.kind || got.record_id_res !== want.record_id_res ||
					got.score_res !== want.score_res || got.last !== want.last) begin
				errors++;
				if (errors <= ERR_PRINT_MAX)
					$display("%0t ns: result mismatch: expected %s, got %s",
						$time, show(want), show(got));
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	rbs_pkg::req_t req;
	logic          strobe;
	rbs_pkg::res_t res;

	record_book book;
	int         sent;
	int         drain;

	record_bubble_sorter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.strobe (strobe),
		.res    (res)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs; a full correct run needs well under
	// a quarter of this.
	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	// Results cannot be held off, so every strobe is checked as it comes.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && strobe === 1'b1)
			book.check_report(res);
	end

	function automatic rbs_pkg::req_t make_request(logic [rbs_pkg::ACTION_W-1:0] action,
			logic [rbs_pkg::ID_W-1:0] id, logic [rbs_pkg::SCORE_W-1:0] sc);
		rbs_pkg::req_t r;
		r.action = action;
		r.record_id = id;
		r.score = sc;
		return r;
	endfunction

	// Scores lean towards the range limits and a few coarse steps, so that
	// ties are common and the stability of the sort is actually exercised.
	// Values above the maximum check the saturation on add.
	function automatic logic [rbs_pkg::SCORE_W-1:0] pick_score();
		case ($urandom_range(0, 4))
			0: begin
				case ($urandom_range(0, 5))
					0: return 14'd0;
					1: return 14'd1;
					2: return 14'd9999;
					3: return rbs_pkg::SCORE_MAX;
					4: return 14'd10001;
					default: return 14'h3fff;
				endcase
			end
			1: return rbs_pkg::SCORE_W'($urandom_range(0, 16383));
			2: return rbs_pkg::SCORE_W'($urandom_range(0, 8) * 1250);
			default: return rbs_pkg::SCORE_W'($urandom_range(0, 10000));
		endcase
	endfunction

	function automatic logic [rbs_pkg::ID_W-1:0] pick_id();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return rbs_pkg::ID_W'($urandom);
		endcase
	endfunction

	// While the store is filling, adds dominate with sorts and best/worst
	// reports mixed in; once full, adds can only be rejected, so the mix
	// shifts towards the reporting actions. The unused action code is noise.
	function automatic rbs_pkg::req_t random_request(bit filling);
		int roll;
		logic [rbs_pkg::ACTION_W-1:0] action;
		roll = $urandom_range(0, 99);
		if (filling)
			action = (roll < 55) ? rbs_pkg::ACT_ADD : (roll < 72) ? rbs_pkg::ACT_SORT :
				(roll < 92) ? rbs_pkg::ACT_EXTREMES : rbs_pkg::ACT_UNUSED;
		else
			action = (roll < 30) ? rbs_pkg::ACT_ADD : (roll < 60) ? rbs_pkg::ACT_SORT :
				(roll < 92) ? rbs_pkg::ACT_EXTREMES : rbs_pkg::ACT_UNUSED;
		return make_request(action, pick_id(), pick_score());
	endfunction

	// Drives one request and returns at the edge that accepts it. Start is
	// left high so that a following request can go straight in; an idle burst
	// first drops start and lets a few cycles pass.
	task automatic send_request(rbs_pkg::req_t r, bit may_idle);
		int gap;
		if (may_idle && $urandom_range(0, 99) < 35) begin
			gap = $urandom_range(1, 17);
			start <= 1'b0;
			req <= make_request(rbs_pkg::ACT_UNUSED, pick_id(), pick_score());
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
		book.note_request(r);
	endtask

	initial begin
		book = new();
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty store answers, ignored code, a single record,
		// saturation, ties at both ends of the range, and the report after a sort.
		send_request(make_request(rbs_pkg::ACT_SORT, pick_id(), pick_score()), 1'b0);
		send_request(make_request(rbs_pkg::ACT_EXTREMES, pick_id(), pick_score()), 1'b1);
		send_request(make_request(rbs_pkg::ACT_UNUSED, '1, 14'h3fff), 1'b0);
		send_request(make_request(rbs_pkg::ACT_ADD, '1, 14'h3fff), 1'b1);
		send_request(make_request(rbs_pkg::ACT_EXTREMES, '0, '0), 1'b0);
		send_request(make_request(rbs_pkg::ACT_SORT, '0, '0), 1'b1);
		send_request(make_request(rbs_pkg::ACT_ADD, '0, 14'd0), 1'b0);
		send_request(make_request(rbs_pkg::ACT_ADD, rbs_pkg::ID_W'($urandom),
			rbs_pkg::SCORE_MAX), 1'b0);
		send_request(make_request(rbs_pkg::ACT_ADD, rbs_pkg::ID_W'($urandom),
			14'd10001), 1'b1);
		send_request(make_request(rbs_pkg::ACT_ADD, rbs_pkg::ID_W'($urandom),
			14'd0), 1'b0);
		send_request(make_request(rbs_pkg::ACT_ADD, rbs_pkg::ID_W'($urandom),
			14'd5000), 1'b0);
		send_request(make_request(rbs_pkg::ACT_EXTREMES, '1, '1), 1'b1);
		send_request(make_request(rbs_pkg::ACT_UNUSED, rbs_pkg::ID_W'($urandom),
			14'd1), 1'b0);
		send_request(make_request(rbs_pkg::ACT_SORT, '1, '1), 1'b0);
		send_request(make_request(rbs_pkg::ACT_EXTREMES, '0, '0), 1'b1);
		send_request(make_request(rbs_pkg::ACT_ADD, 31'h2aaa_aaaa, 14'd1), 1'b0);
		send_request(make_request(rbs_pkg::ACT_ADD, 31'h5555_5555, 14'd9999), 1'b1);
		send_request(make_request(rbs_pkg::ACT_SORT, '0, '0), 1'b0);

		// Random part. Only requests that the block acts on are counted.
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			rbs_pkg::req_t r;
			r = random_request(book.held < rbs_pkg::CAPACITY_DEF);
			send_request(r, sent < RANDOM_REQUESTS - QUIET_TAIL);
			if (r.action != rbs_pkg::ACT_UNUSED)
				sent++;
		end
		start <= 1'b0;

		// Let the outstanding results arrive, then watch a while longer for
		// anything spurious.
		drain = 0;
		while (book.pending.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (book.pending.size() != 0) begin
			$display("%0t ns: %0d results never arrived: expected %s, got nothing",
				$time, book.pending.size(), book.show(book.pending[0]));
			book.errors++;
		end

		$display("Covered %0d adds, %0d rejected on a full store, %0d sorts, %0d best/worst",
			book.n_add, book.n_reject, book.n_sort, book.n_extremes);
		$display("requests, %0d empty-store answers and %0d ignored codes; %0d results checked.",
			book.n_empty, book.n_ignored, book.checked);

		if (book.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
